// ===== rtl/array_list_insert_delete_assert.svh =====
// Assertion macros for the ordered list block.
// Used by the port checker; no other dependencies.
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ALID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list checker: same-cycle rule violated");

// Next-cycle implication, disabled during reset.
`define ALID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list checker: next-cycle rule violated");

`endif

// ===== rtl/alid_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the ordered list block. No dependencies.
`timescale 1ns / 1ps

package alid_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PC_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_FRONT  = 3'd1,
    FUNC_AT     = 3'd2,
    FUNC_DELETE = 3'd3,
    FUNC_DUMP   = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEL  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PLACE      = 3'd1,
    OP_REPORT     = 3'd2,
    OP_MATCH      = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_DUMP_START = 3'd5,
    OP_DUMP_STEP  = 3'd6
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic full;
    logic pos_ok;
    logic found;
    logic dump_last;
  } sts_t;

endpackage

// ===== rtl/alid_dpath.sv =====
// Datapath: shifting cell chain, entry count, match vector, dump index
// and the output register. Depends on alid_pkg.
`timescale 1ns / 1ps

module alid_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  alid_pkg::cmd_t                       cmd_i,
  input  logic [alid_pkg::FUNC_W-1:0]          in_func_i,
  input  logic signed [alid_pkg::VALUE_W-1:0]  in_value_i,
  input  logic [alid_pkg::POS_W-1:0]           in_position_i,
  input  logic                                 out_stall_i,
  output alid_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  output logic [alid_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [alid_pkg::VALUE_W-1:0]  out_element_o,
  output logic [alid_pkg::SLOT_W-1:0]          out_element_slot_o,
  output logic [alid_pkg::COUNT_W-1:0]         out_entry_count_o,
  output logic                                 out_last_o
);
  import alid_pkg::*;

  logic [DATA_WIDTH-1:0] cells_q [DEPTH];
  logic [DATA_WIDTH-1:0] below   [DEPTH];
  logic [DATA_WIDTH-1:0] above   [DEPTH];
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DEPTH-1:0]      match_q, match_d;
  logic [DEPTH-1:0]      shift_en;
  logic [DATA_WIDTH-1:0] word;
  logic [IDX_W-1:0]      slot;
  logic                  out_load;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [VALUE_W-1:0]    element_q, element_d;
  logic [SLOT_W-1:0]     eslot_q, eslot_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  last_q, last_d;

  assign word = DATA_WIDTH'($unsigned(in_value_i));

  always_comb begin
    case (func_e'(in_func_i))
      FUNC_APPEND: slot = IDX_W'(fill_q);
      FUNC_FRONT:  slot = '0;
      default:     slot = IDX_W'(in_position_i - POS_W'(1));
    endcase
  end

  always_comb begin
    below[0]       = '0;
    above[DEPTH-1] = '0;
    for (int i = 1; i < DEPTH; i++) begin
      below[i]   = cells_q[i-1];
      above[i-1] = cells_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i]  = (cells_q[i] == word) && (CNT_W'(i) < fill_q);
      shift_en[i] = |(match_q & ~({DEPTH{1'b1}} << (i + 1)));
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.full      = (fill_q == CNT_W'(DEPTH));
  assign sts_o.pos_ok    = (in_position_i != '0) &&
                           (PC_W'(in_position_i) <= PC_W'(fill_q) + PC_W'(1));
  assign sts_o.found     = |match_q;
  assign sts_o.dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);

  always_comb begin
    fill_d = fill_q;
    idx_d  = idx_q;
    unique case (cmd_i.op)
      OP_PLACE:      fill_d = fill_q + CNT_W'(1);
      OP_REMOVE:     fill_d = fill_q - CNT_W'(1);
      OP_DUMP_START: idx_d  = '0;
      OP_DUMP_STEP:  idx_d  = idx_q + IDX_W'(1);
      default: ;
    endcase
  end

  assign out_load = (cmd_i.op == OP_PLACE) || (cmd_i.op == OP_REPORT) ||
                    (cmd_i.op == OP_REMOVE) || (cmd_i.op == OP_DUMP_STEP);

  always_comb begin
    out_valid_d = out_load ? 1'b1 : (out_stall_i && out_valid_q);
    status_d    = cmd_i.status;
    element_d   = '0;
    eslot_d     = '0;
    count_d     = COUNT_W'(fill_d);
    last_d      = 1'b1;
    if (cmd_i.op == OP_DUMP_STEP) begin
      element_d = VALUE_W'(cells_q[idx_q]);
      eslot_d   = SLOT_W'(idx_q);
      last_d    = sts_o.dump_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.op == OP_PLACE) begin
        if (IDX_W'(i) == slot) begin
          cells_q[i] <= word;
        end else if (IDX_W'(i) > slot) begin
          cells_q[i] <= below[i];
        end
      end else if (cmd_i.op == OP_REMOVE && shift_en[i]) begin
        cells_q[i] <= above[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MATCH) begin
      match_q <= match_d;
    end
    if (out_load) begin
      status_q  <= status_d;
      element_q <= element_d;
      eslot_q   <= eslot_d;
      count_q   <= count_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = status_q;
  assign out_element_o      = $signed(element_q);
  assign out_element_slot_o = eslot_q;
  assign out_entry_count_o  = count_q;
  assign out_last_o         = last_q;

endmodule

// ===== rtl/alid_ctrl.sv =====
// Controller: decodes each item and sequences delete and dump steps,
// driving the datapath by command. Depends on alid_pkg.
`timescale 1ns / 1ps

module alid_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [alid_pkg::FUNC_W-1:0] in_func_i,
  output logic                        in_stall_o,
  input  alid_pkg::sts_t              sts_i,
  output alid_pkg::cmd_t              cmd_o
);
  import alid_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = ST_OK;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          unique case (func_e'(in_func_i)) inside
            FUNC_APPEND, FUNC_FRONT: begin
              if (sts_i.full) begin
                cmd_o.op     = OP_REPORT;
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.op = OP_PLACE;
              end
            end
            FUNC_AT: begin
              if (sts_i.full) begin
                cmd_o.op     = OP_REPORT;
                cmd_o.status = ST_FULL;
              end else if (!sts_i.pos_ok) begin
                cmd_o.op     = OP_REPORT;
                cmd_o.status = ST_BADPOS;
              end else begin
                cmd_o.op = OP_PLACE;
              end
            end
            FUNC_DELETE: begin
              if (sts_i.empty) begin
                cmd_o.op     = OP_REPORT;
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.op = OP_MATCH;
                state_d  = S_DEL;
              end
            end
            FUNC_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.op     = OP_REPORT;
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.op = OP_DUMP_START;
                state_d  = S_DUMP;
              end
            end
            default: begin
              cmd_o.op = OP_REPORT;
            end
          endcase
        end
      end
      S_DEL: begin
        if (sts_i.out_free) begin
          if (sts_i.found) begin
            cmd_o.op = OP_REMOVE;
          end else begin
            cmd_o.op     = OP_REPORT;
            cmd_o.status = ST_NOTFOUND;
          end
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_DUMP_STEP;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/array_list_insert_delete.sv =====
// Top level of the ordered list block: joins controller and datapath.
// Depends on alid_pkg, alid_ctrl and alid_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: func, value
//   and position. Output channel (out_valid_o / out_stall_i) carries one
//   result item per beat: status, element, slot, entry count and last.
//   Append, insert front and insert at position give a single result in the
//   cycle after acceptance; a new item can be taken each cycle, limited by the
//   single-entry output register. Delete compares every cell in parallel,
//   registers the match vector, then shifts the chain down, or reports not
//   found if no cell matched. Dump first clears the dump index, then emits
//   one stored entry per cycle while the output is not stalled; last marks
//   the final entry. Dump or delete on an empty list gives one result with
//   status empty.
//   Input is stalled while a delete or dump is in progress, and whenever
//   the output register holds a result that the receiver is stalling.
//   A stalled result holds its payload until taken.
//   Reset empties the list and clears the output valid flag; cell contents
//   are not cleared since only slots below the count are ever read.
`timescale 1ns / 1ps

module array_list_insert_delete (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [alid_pkg::FUNC_W-1:0]          in_func_i,
  input  logic signed [alid_pkg::VALUE_W-1:0]  in_value_i,
  input  logic [alid_pkg::POS_W-1:0]           in_position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [alid_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [alid_pkg::VALUE_W-1:0]  out_element_o,
  output logic [alid_pkg::SLOT_W-1:0]          out_element_slot_o,
  output logic [alid_pkg::COUNT_W-1:0]         out_entry_count_o,
  output logic                                 out_last_o
);
  import alid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  alid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alid_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .in_func_i          (in_func_i),
    .in_value_i         (in_value_i),
    .in_position_i      (in_position_i),
    .out_stall_i        (out_stall_i),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_element_o      (out_element_o),
    .out_element_slot_o (out_element_slot_o),
    .out_entry_count_o  (out_entry_count_o),
    .out_last_o         (out_last_o)
  );

endmodule

// ===== rtl/alid_checker.sv =====
// Port-level checker for the ordered list block, bound to the top level.
// Depends on alid_pkg and array_list_insert_delete_assert.svh.
`timescale 1ns / 1ps
`include "array_list_insert_delete_assert.svh"

module alid_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [alid_pkg::FUNC_W-1:0]          in_func_i,
  input logic signed [alid_pkg::VALUE_W-1:0]  in_value_i,
  input logic [alid_pkg::POS_W-1:0]           in_position_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [alid_pkg::STATUS_W-1:0]        out_status_o,
  input logic signed [alid_pkg::VALUE_W-1:0]  out_element_o,
  input logic [alid_pkg::SLOT_W-1:0]          out_element_slot_o,
  input logic [alid_pkg::COUNT_W-1:0]         out_entry_count_o,
  input logic                                 out_last_o
);
  import alid_pkg::*;

  logic in_seen;

  assign in_seen = in_valid_i && !in_stall_o && (in_func_i == in_func_i) &&
                   (in_value_i == in_value_i) && (in_position_i == in_position_i);

  `ALID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_status_o) && $stable(out_element_o) && $stable(out_element_slot_o) && $stable(out_entry_count_o) && $stable(out_last_o))

  `ALID_ASSERT_IMPL(a_fail_single, clk_i, rst_ni, out_valid_o && out_status_o != ST_OK,
    out_last_o && out_element_o == '0 && out_element_slot_o == '0)

  `ALID_ASSERT_IMPL(a_full_count, clk_i, rst_ni, out_valid_o && out_status_o == ST_FULL,
    out_entry_count_o == COUNT_W'(DEPTH))

  `ALID_ASSERT_IMPL(a_dump_blocks, clk_i, rst_ni, (out_valid_o && !out_last_o) || 1'b0,
    in_stall_o && !in_seen)

endmodule

bind array_list_insert_delete alid_checker u_checker (.*);
